// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the frame checker project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated off while rst is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, gated off while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/crcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfc_pkg
// types, constants and the crc byte update for the crc-16/arc frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package crcfc_pkg;

   localparam int MAX_PAYLOAD = 4096;
   localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 3);
   localparam int LENGTH_W    = 13;
   localparam int BYTE_W      = 8;
   localparam int CRC_W       = 16;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LENGTH_W;

   localparam logic [CRC_W-1:0]    CRC_POLY       = 16'hA001;
   localparam logic [BYTE_W-1:0]   BYTE_MASK      = 8'hFF;
   localparam logic [LENGTH_W-1:0] LENGTH_DEFAULT = 13'd256;

   // result queue
   localparam int PUSH_MAX    = 3;
   localparam int PUSH_W      = 2;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE           = 1'b0,
      CSR_PAYLOAD_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_CHECK    = 1'b0,
      MODE_GENERATE = 1'b1
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_CRC     = 2'd1,
      KIND_VERDICT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] out_byte;
      logic              crc_match;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [PUSH_W-1:0]                count;
      rsp_item_type [PUSH_MAX-1:0]      item;
   } push_type;

   function automatic logic [CRC_W-1:0] crc_absorb(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b & BYTE_MASK};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/crcfc_if.sv =====
// ----------------------------------------------------------------------------
// crcfc_if
// valid/ready channel interfaces: byte input, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface crcfc_req_if import crcfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, data_byte, frame_start, input ready);
   modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface crcfc_rsp_if import crcfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] out_byte;
   logic              crc_match;
   logic              last;

   modport source (output valid, kind, out_byte, crc_match, last, input ready);
   modport sink   (input valid, kind, out_byte, crc_match, last, output ready);
endinterface

interface crcfc_csr_if import crcfc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/crc16_arc_frame_checker.sv =====
// ----------------------------------------------------------------------------
// crc16_arc_frame_checker
// crc-16/arc frame generator and checker over a valid/ready byte stream
// ----------------------------------------------------------------------------
//  channel   dir  payload                              transfer when
//  req_chan  in   data_byte, frame_start               valid & ready
//  rsp_chan  out  kind, out_byte, crc_match, last      valid & ready
//  csr_chan  in   index, data                          valid & ready (always ready)
//
//  one input byte per cycle while req_chan.ready is high; the crc update is one unrolled xor network
//  results go through an eight-entry queue, read out one per cycle while rsp_chan.ready is high
//  the last payload byte in generate mode makes three results: that byte and
//  both crc bytes; req_chan.ready drops while the queue is short
//  synchronous reset clears crc, counter, held byte and queue, and presets the mode and length registers
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_arc_frame_checker import crcfc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   crcfc_req_if.sink  req_chan,
   crcfc_rsp_if.source rsp_chan,
   crcfc_csr_if.sink  csr_chan
);

   mode_type            mode_ff, mode_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [CRC_W-1:0]    crc_ff, crc_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0]   held_ff, held_in;

   logic                room;
   logic                accept;
   logic [COUNT_W-1:0]  len_eff;
   logic [CRC_W-1:0]    crc_base, crc_next;
   logic [COUNT_W-1:0]  count_base, count_plus;
   push_type            push;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = room;
   assign accept         = req_chan.valid & room;

   // register writes
   always_comb begin
      mode_in   = mode_ff;
      length_in = length_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_MODE:           mode_in   = mode_type'(csr_chan.data[0]);
            CSR_PAYLOAD_LENGTH: length_in = csr_chan.data[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (length_ff == '0) begin
         len_eff = COUNT_W'(1);
      end else if (32'(length_ff) > 32'(MAX_PAYLOAD)) begin
         len_eff = COUNT_W'(MAX_PAYLOAD);
      end else begin
         len_eff = COUNT_W'(length_ff);
      end
   end

   // frame engine
   always_comb begin
      crc_base   = req_chan.frame_start ? '0 : crc_ff;
      count_base = req_chan.frame_start ? '0 : count_ff;
      crc_next   = crc_absorb(crc_base, req_chan.data_byte);
      count_plus = count_base + COUNT_W'(1);

      crc_in     = crc_ff;
      count_in   = count_ff;
      held_in    = held_ff;
      push       = '0;

      if (accept) begin
         crc_in   = crc_base;
         count_in = count_base;
         if (mode_ff == MODE_GENERATE) begin
            push.item[0].kind     = KIND_PAYLOAD;
            push.item[0].out_byte = req_chan.data_byte;
            if (count_plus >= len_eff) begin
               push.item[1].kind     = KIND_CRC;
               push.item[1].out_byte = crc_next[BYTE_W-1:0];
               push.item[2].kind     = KIND_CRC;
               push.item[2].out_byte = crc_next[CRC_W-1:BYTE_W];
               push.item[2].last     = 1'b1;
               push.count            = PUSH_W'(3);
               crc_in                = '0;
               count_in              = '0;
            end else begin
               push.count = PUSH_W'(1);
               crc_in     = crc_next;
               count_in   = count_plus;
            end
         end else begin
            if (count_base < len_eff) begin
               crc_in   = crc_next;
               count_in = count_plus;
            end else if (count_base == len_eff) begin
               held_in  = req_chan.data_byte;
               count_in = count_plus;
            end else begin
               push.item[0].kind      = KIND_VERDICT;
               push.item[0].crc_match = ({req_chan.data_byte, held_ff} == crc_base);
               push.item[0].last      = 1'b1;
               push.count             = PUSH_W'(1);
               crc_in                 = '0;
               count_in               = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_CHECK;
         length_ff <= LENGTH_DEFAULT;
         crc_ff    <= '0;
         count_ff  <= '0;
         held_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         length_ff <= length_in;
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         held_ff   <= held_in;
      end
   end

   crcfc_out_queue u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hdl/crcfc_out_queue.sv =====
// ----------------------------------------------------------------------------
// crcfc_out_queue
// small result queue, up to three written per cycle, one read out when ready
// ----------------------------------------------------------------------------
`default_nettype none

module crcfc_out_queue import crcfc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   crcfc_rsp_if.source   rsp
);

   rsp_item_type [QUEUE_DEPTH-1:0] entry_ff;
   logic [QPTR_W-1:0]              wr_ff, wr_in;
   logic [QPTR_W-1:0]              rd_ff, rd_in;
   logic [QPTR_W:0]                fill_ff, fill_in;
   logic                           pop;
   rsp_item_type                   head;

   assign pop  = rsp.valid & rsp.ready;
   assign head = entry_ff[rd_ff];

   assign rsp.valid     = (fill_ff != '0);
   assign rsp.kind      = head.kind;
   assign rsp.out_byte  = head.out_byte;
   assign rsp.crc_match = head.crc_match;
   assign rsp.last      = head.last;

   // enough space for a full burst from the next transfer
   assign room = (fill_ff <= (QPTR_W+1)'(QUEUE_DEPTH - PUSH_MAX));

   always_comb begin
      wr_in   = wr_ff + QPTR_W'(push.count);
      rd_in   = rd_ff + QPTR_W'(pop);
      fill_in = fill_ff + (QPTR_W+1)'(push.count) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PUSH_MAX; i++) begin
         if (PUSH_W'(i) < push.count) begin
            entry_ff[wr_ff + QPTR_W'(i)] <= push.item[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/crcfc_checker.sv =====
// ----------------------------------------------------------------------------
// crcfc_checker
// port-level assertions for the frame checker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crcfc_checker import crcfc_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [BYTE_W-1:0] rsp_out_byte,
   input wire logic              rsp_crc_match,
   input wire logic              rsp_last
);

   `ASSERT_NEXT(a_rsp_empty_after_reset, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLY(a_verdict_shape, clock, reset,
                 rsp_valid && rsp_kind == KIND_VERDICT, rsp_out_byte == '0 && rsp_last)
   `ASSERT_IMPLY(a_payload_shape, clock, reset,
                 rsp_valid && rsp_kind == KIND_PAYLOAD, !rsp_last && !rsp_crc_match)

endmodule

bind crc16_arc_frame_checker crcfc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_crc_match (rsp_chan.crc_match),
   .rsp_last      (rsp_chan.last)
);

`default_nettype wire

// ===== dv/crc16_arc_frame_checker_tb.sv =====
// ----------------------------------------------------------------------------
// crc16_arc_frame_checker_tb
// self-checking testbench for the crc-16/arc frame checker and generator
// ----------------------------------------------------------------------------
// drives bytes, register writes and result back-pressure through the three
// valid/ready channels. every accepted byte runs through a behavioral copy of
// the frame logic, which queues the results it should cause; each result
// transfer is compared with the oldest queued one. covers both modes, length
// clamping, counts past the frame end and long stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module crc16_arc_frame_checker_tb;
   import crcfc_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 200;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ITEMS  = 370;

   logic clock = 1'b0;
   logic reset = 1'b1;

   crcfc_req_if req_chan ();
   crcfc_rsp_if rsp_chan ();
   crcfc_csr_if csr_chan ();

   crc16_arc_frame_checker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   mode_type            model_mode;
   logic [LENGTH_W-1:0] model_length;
   logic [CRC_W-1:0]    model_crc;
   int unsigned         model_count;
   logic [BYTE_W-1:0]   model_held;
   rsp_item_type        pending_results [$];

   int          fail_count = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int          rsp_hold_cycles = 0;
   int unsigned cycle_count = 0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic logic [CRC_W-1:0] crc16_arc_update(input logic [CRC_W-1:0] crc,
                                                         input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      logic             feedback;
      c = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         feedback = c[0] ^ data[i];
         c = c >> 1;
         if (feedback) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic int unsigned effective_length(input logic [LENGTH_W-1:0] length);
      int unsigned n;
      n = length;
      if (n < 1) begin
         n = 1;
      end
      if (n > MAX_PAYLOAD) begin
         n = MAX_PAYLOAD;
      end
      return n;
   endfunction

   function automatic rsp_item_type result_of(input kind_type kind, input logic [BYTE_W-1:0] b,
                                              input logic match, input logic last);
      rsp_item_type r;
      r.kind      = kind;
      r.out_byte  = b;
      r.crc_match = match;
      r.last      = last;
      return r;
   endfunction

   function automatic void predict_frame_results(input logic [BYTE_W-1:0] data,
                                                 input logic start);
      int unsigned len;
      len = effective_length(model_length);
      if (start) begin
         model_crc   = '0;
         model_count = 0;
      end
      if (model_mode == MODE_GENERATE) begin
         model_crc = crc16_arc_update(model_crc, data);
         model_count++;
         pending_results.push_back(result_of(KIND_PAYLOAD, data, 1'b0, 1'b0));
         if (model_count >= len) begin
            pending_results.push_back(result_of(KIND_CRC, model_crc[7:0], 1'b0, 1'b0));
            pending_results.push_back(result_of(KIND_CRC, model_crc[15:8], 1'b0, 1'b1));
            model_crc   = '0;
            model_count = 0;
         end
      end else if (model_count < len) begin
         model_crc = crc16_arc_update(model_crc, data);
         model_count++;
      end else if (model_count == len) begin
         model_held = data;
         model_count++;
      end else begin
         pending_results.push_back(result_of(KIND_VERDICT, '0,
                                             {data, model_held} == model_crc, 1'b1));
         model_crc   = '0;
         model_count = 0;
      end
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic start);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 9) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= data;
      req_chan.frame_start <= start;
      do @(posedge clock); while (!req_chan.ready);
      predict_frame_results(data, start);
   endtask

   task automatic write_register(input csr_index_type reg_index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= reg_index;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      if (reg_index == CSR_MODE) begin
         model_mode = mode_type'(value[0]);
      end else begin
         model_length = value;
      end
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // the last byte of a check frame may still be in flight with nothing queued
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame_config(input mode_type new_mode,
                                   input logic [LENGTH_W-1:0] new_length);
      wait_drained();
      write_register(CSR_MODE, CSR_DATA_W'(new_mode));
      write_register(CSR_PAYLOAD_LENGTH, new_length);
   endtask

   task automatic test_check_frames();
      logic [CRC_W-1:0] crc;
      set_frame_config(MODE_CHECK, 13'd3);
      crc = crc16_arc_update(16'h0000, 8'h00);
      crc = crc16_arc_update(crc, 8'hFF);
      crc = crc16_arc_update(crc, 8'h5A);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(crc[7:0], 1'b0);
      send_byte(crc[15:8], 1'b0);
      // second frame restarts on its own, bad trailer
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(crc[7:0], 1'b0);
      send_byte(crc[15:8] ^ 8'h80, 1'b0);
   endtask

   task automatic test_generate_frames();
      // zero length acts as one
      set_frame_config(MODE_GENERATE, 13'd0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      set_frame_config(MODE_GENERATE, 13'd2);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h3C, 1'b0);
   endtask

   task automatic test_count_beyond_frame();
      // length lowered below the count in check mode gives a verdict
      set_frame_config(MODE_CHECK, 13'd6);
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      set_frame_config(MODE_CHECK, 13'd1);
      send_byte(8'h44, 1'b0);
      // switch to generate with the trailer half taken
      set_frame_config(MODE_CHECK, 13'd2);
      send_byte(8'h55, 1'b1);
      send_byte(8'h66, 1'b0);
      send_byte(8'h77, 1'b0);
      set_frame_config(MODE_GENERATE, 13'd2);
      send_byte(8'h88, 1'b0);
      // length lowered mid-frame in generate mode
      set_frame_config(MODE_GENERATE, 13'd10);
      send_byte(8'h99, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hBB, 1'b0);
      set_frame_config(MODE_GENERATE, 13'd2);
      send_byte(8'hCC, 1'b0);
   endtask

   task automatic test_output_backpressure();
      logic [BYTE_W-1:0] b;
      set_frame_config(MODE_GENERATE, 13'd1);
      req_idle_on     = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (24) begin
         b = BYTE_W'($urandom_range(0, 255));
         send_byte(b, 1'($urandom_range(0, 1)));
      end
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_frames();
      int                  sent;
      int unsigned         len;
      bit                  big;
      mode_type            phase_mode;
      logic [LENGTH_W-1:0] length;
      logic [CRC_W-1:0]    crc;
      logic [BYTE_W-1:0]   b;
      logic [BYTE_W-1:0]   lo;
      logic [BYTE_W-1:0]   hi;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         big        = ($urandom_range(0, 9) == 0);
         phase_mode = mode_type'($urandom_range(0, 1));
         length     = big ? LENGTH_W'($urandom_range(0, 8191))
                          : LENGTH_W'($urandom_range(0, 12));
         set_frame_config(phase_mode, length);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         len = effective_length(length);
         repeat ($urandom_range(2, 6)) begin
            if (big || $urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 4)) begin
                  b = BYTE_W'($urandom_range(0, 255));
                  send_byte(b, 1'($urandom_range(0, 1)));
                  sent++;
               end
            end else begin
               crc = '0;
               for (int i = 0; i < len; i++) begin
                  b   = BYTE_W'($urandom_range(0, 255));
                  crc = crc16_arc_update(crc, b);
                  send_byte(b, i == 0);
                  sent++;
                  // truncated frame
                  if ($urandom_range(0, 31) == 0) begin
                     break;
                  end
               end
               if (phase_mode == MODE_CHECK && $urandom_range(0, 7) != 0) begin
                  lo = crc[7:0];
                  hi = crc[15:8];
                  if ($urandom_range(0, 2) == 0) begin
                     if ($urandom_range(0, 1) == 0) begin
                        lo = lo ^ BYTE_W'($urandom_range(1, 255));
                     end else begin
                        hi = hi ^ BYTE_W'($urandom_range(1, 255));
                     end
                  end
                  send_byte(lo, 1'b0);
                  send_byte(hi, 1'b0);
                  sent += 2;
               end
            end
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin : rsp_ready_driver
      int wait_n;
      rsp_chan.ready = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            repeat (rsp_hold_cycles) begin
               @(negedge clock);
               rsp_chan.ready <= 1'b0;
            end
            rsp_hold_cycles = 0;
         end
         wait_n = rsp_idle_on ? $urandom_range(0, 9) : 0;
         repeat (wait_n) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid && rsp_hold_cycles == 0);
      end
   end

   always @(posedge clock) begin : result_checker
      rsp_item_type actual;
      rsp_item_type wanted;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         actual = result_of(kind_type'(rsp_chan.kind), rsp_chan.out_byte,
                            rsp_chan.crc_match, rsp_chan.last);
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("unexpected result: kind %0d byte %02h match %0b last %0b",
                        actual.kind, actual.out_byte, actual.crc_match, actual.last);
            end
         end else begin
            wanted = pending_results.pop_front();
            if (actual !== wanted) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("result mismatch: expected kind %0d byte %02h match %0b last %0b",
                           wanted.kind, wanted.out_byte, wanted.crc_match, wanted.last);
                  $display("                 actual   kind %0d byte %02h match %0b last %0b",
                           actual.kind, actual.out_byte, actual.crc_match, actual.last);
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("crc16_arc_frame_checker test failed");
      $finish;
   end

   initial begin : test_sequence
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = '0;
      req_chan.frame_start = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_MODE;
      csr_chan.data        = '0;
      model_mode   = MODE_CHECK;
      model_length = LENGTH_DEFAULT;
      model_crc    = '0;
      model_count  = 0;
      model_held   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_check_frames();
      test_generate_frames();
      test_count_beyond_frame();
      test_output_backpressure();
      test_random_frames();
      wait_drained();

      if (fail_count == 0) begin
         $display("crc16_arc_frame_checker test passed");
      end else begin
         $display("crc16_arc_frame_checker test failed");
      end
      $finish;
   end

endmodule
